// File: hdl/assert_macros.svh
// Assertion macros shared by the tap tempo RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define TTE_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("tap tempo assertion failed");

// next-cycle implication under reset
`define TTE_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("tap tempo assertion failed");

`endif

// File: hdl/tte_pkg.sv
// Package: constants, widths and register codes of the tap tempo estimator
`timescale 1ns / 1ps
package tte_pkg;
	localparam int HISTORY_DEPTH_DEF = 32;
	localparam int TIME_W  = 32;
	localparam int TEMPO_W = 24;
	localparam int TAPS_W  = 6;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;
	// widths sized for the largest history depth of 256
	localparam int SUM_W   = 40;
	localparam int WSUM_W  = 48;
	localparam int NUM_W   = 57;
	localparam int LM_W    = 32;
	localparam int DEN_W   = 29;
	localparam int K_W     = 41;
	localparam int KD_W    = 70;
	localparam int WORD_W  = 64;

	localparam logic [TIME_W-1:0] RESTART_GAP_MS = 32'd2000;
	localparam logic [K_W-1:0]    K_STD          = 41'd600000000;
	localparam logic [24:0]       K_LEGACY       = 25'd25000000;
	localparam logic [13:0]       SCALE_10K      = 14'd10000;
	localparam logic [31:0]       RECIP3         = 32'hAAAAAAAB;
	localparam logic [WORD_W-1:0] RAW_SAT        = 64'h0000_0100_0000_0000;

	typedef enum logic [IDX_W-1:0] {
		REG_TEMPO_MIN     = 3'd0,
		REG_TEMPO_MAX     = 3'd1,
		REG_LEGACY_MODE   = 3'd2,
		REG_TICKS_PER_ROW = 3'd3,
		REG_ROWS_PER_BEAT = 3'd4,
		REG_FRACTION      = 3'd5
	} cfg_reg_t;

	localparam logic [TEMPO_W-1:0] TEMPO_MIN_RST = 24'd320000;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX_RST = 24'd2550000;
endpackage

// File: hdl/tte_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module tte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/tap_tempo_estimator.sv
// Top level: tap history, least-squares slope and tempo sequencer
//
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//  tap     | in        | in_valid/in_stall  | tap_time_ms
//  result  | out       | out_valid/out_stall| tempo, taps_used
//
// Each tap is taken; then, with at least two kept taps, the history RAM is swept one entry
// per cycle, four multiply steps run, the restoring divider yields one quotient bit a cycle,
// and rounding, scaling and clamping finish. A zero numerator or an overflowing quotient skips the divider.
// Reset clears the tap count, previous tap and head, and loads the config defaults; RAM is not cleared.
// in_stall is high while a tap is in work; a held result only delays the final step.
`timescale 1ns / 1ps
module tap_tempo_estimator
	import tte_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [TIME_W-1:0]  tap_time_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [TEMPO_W-1:0] tempo,
	output logic [TAPS_W-1:0]  taps_used
);
	`include "assert_macros.svh"

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_M1, S_M2, S_M3, S_M4, S_DIV, S_RND, S_SCALE, S_CLAMP
	} state_t;

	state_t state_q;

	logic [TEMPO_W-1:0] tempo_min_q, tempo_max_q;
	logic               legacy_q, fraction_q;
	logic [7:0]         tpr_q, rpb_q;

	logic [TIME_W-1:0] prev_q, t0_q;
	logic [CW-1:0]     count_q, issue_q;
	logic [AW-1:0]     head_q, rd_ptr_q, idx_s1;
	logic              vld_s1;
	logic [SUM_W-1:0]  sum_q;
	logic [WSUM_W-1:0] wsum_q;
	logic [NUM_W-1:0]  nw_q, hs_q, num_q;
	logic [LM_W-1:0]   lm_q;
	logic [DEN_W-1:0]  den_q;
	logic [15:0]       tprb_q;
	logic [K_W-1:0]    k_q;
	logic [55:0]       kd_lo_q;
	logic [54:0]       kd_hi_q;
	logic [WORD_W-1:0] div_q, rem_q, lo_q, quo_q, raw_q;
	logic [5:0]        bit_q;

	logic              in_xfer, restart, load_out;
	logic [CW-1:0]     cnt0, cnt1, count_n, n_m1;
	logic [AW-1:0]     head_n, waddr;
	logic [AW:0]       head_inc, wsum_ptr, rd_inc;
	logic [TIME_W-1:0] rdata, d_w;
	logic [2*CW-1:0]   half_w, mpl_w;
	logic [KD_W-1:0]   kd_w;
	logic              carry_w, ge_w;
	logic [WORD_W-1:0] remsh_w, q2_w;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign restart  = ((tap_time_ms - prev_q) >= RESTART_GAP_MS);
	assign load_out = (state_q == S_CLAMP) && (!out_valid || !out_stall);

	always_comb begin
		cnt0     = restart ? '0 : count_q;
		head_inc = {1'b0, head_q} + 1'b1;
		if (cnt0 == DEPTH_C) begin
			head_n = (head_inc >= (AW+1)'(HISTORY_DEPTH)) ? '0 : head_inc[AW-1:0];
			cnt1   = DEPTH_C - 1'b1;
		end else begin
			head_n = head_q;
			cnt1   = cnt0;
		end
		wsum_ptr = {1'b0, head_n} + (AW+1)'(cnt1);
		waddr    = (wsum_ptr >= (AW+1)'(HISTORY_DEPTH)) ?
			AW'(wsum_ptr - (AW+1)'(HISTORY_DEPTH)) : wsum_ptr[AW-1:0];
		count_n  = cnt1 + 1'b1;
		rd_inc   = {1'b0, rd_ptr_q} + 1'b1;
		n_m1     = count_q - 1'b1;
		d_w      = (idx_s1 == '0) ? '0 : (rdata - t0_q);
		half_w   = (2*CW)'(({{CW{1'b0}}, count_q} * {{CW{1'b0}}, n_m1}) >> 1);
		mpl_w    = (2*CW)'(({{CW{1'b0}}, count_q} * ({{CW{1'b0}}, count_q} + 1'b1)) >> 1);
		kd_w     = KD_W'(kd_lo_q) + (KD_W'(kd_hi_q) << 15);
		carry_w  = rem_q[WORD_W-1];
		remsh_w  = {rem_q[WORD_W-2:0], lo_q[WORD_W-1]};
		ge_w     = carry_w || (remsh_w >= div_q);
		q2_w     = quo_q + WORD_W'(rem_q >= (div_q - rem_q));
	end

	tte_ram #(.WIDTH(TIME_W), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (waddr),
		.wdata (tap_time_ms),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tempo_min_q <= TEMPO_MIN_RST;
			tempo_max_q <= TEMPO_MAX_RST;
			legacy_q    <= 1'b0;
			tpr_q       <= 8'd6;
			rpb_q       <= 8'd4;
			fraction_q  <= 1'b1;
			prev_q      <= '0;
			count_q     <= '0;
			head_q      <= '0;
			vld_s1      <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TEMPO_MIN:     tempo_min_q <= cfg_data[TEMPO_W-1:0];
					REG_TEMPO_MAX:     tempo_max_q <= cfg_data[TEMPO_W-1:0];
					REG_LEGACY_MODE:   legacy_q    <= cfg_data[0];
					REG_TICKS_PER_ROW: tpr_q       <= cfg_data[7:0];
					REG_ROWS_PER_BEAT: rpb_q       <= cfg_data[7:0];
					REG_FRACTION:      fraction_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			vld_s1 <= (state_q == S_RD) && (issue_q < count_q);
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						prev_q   <= tap_time_ms;
						head_q   <= head_n;
						count_q  <= count_n;
						rd_ptr_q <= head_n;
						issue_q  <= '0;
						sum_q    <= '0;
						wsum_q   <= '0;
						if (count_n >= CW'(2)) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (issue_q < count_q) begin
						idx_s1   <= AW'(issue_q);
						issue_q  <= issue_q + 1'b1;
						rd_ptr_q <= (rd_inc >= (AW+1)'(HISTORY_DEPTH)) ? '0 : rd_inc[AW-1:0];
					end
					if (vld_s1) begin
						if (idx_s1 == '0) begin
							t0_q <= rdata;
						end
						sum_q  <= sum_q + SUM_W'(d_w);
						wsum_q <= wsum_q + WSUM_W'(idx_s1) * WSUM_W'(d_w);
						if (idx_s1 == AW'(n_m1)) begin
							state_q <= S_M1;
						end
					end
				end
				S_M1: begin
					nw_q    <= NUM_W'(count_q) * NUM_W'(wsum_q);
					hs_q    <= NUM_W'(half_w) * NUM_W'(sum_q);
					lm_q    <= LM_W'(half_w) * LM_W'(mpl_w);
					tprb_q  <= tpr_q * rpb_q;
					state_q <= S_M2;
				end
				S_M2: begin
					num_q   <= (nw_q >= hs_q) ? (nw_q - hs_q) : '0;
					den_q   <= DEN_W'(({32'd0, lm_q} * {32'd0, RECIP3}) >> 33);
					k_q     <= legacy_q ? K_W'(K_LEGACY) * K_W'(tprb_q) : K_STD;
					state_q <= S_M3;
				end
				S_M3: begin
					kd_lo_q <= k_q * den_q[14:0];
					kd_hi_q <= k_q * den_q[DEN_W-1:15];
					div_q   <= fraction_q ? WORD_W'(num_q) :
						WORD_W'(num_q) * WORD_W'(SCALE_10K);
					state_q <= S_M4;
				end
				S_M4: begin
					rem_q <= WORD_W'(kd_w[KD_W-1:WORD_W]);
					lo_q  <= kd_w[WORD_W-1:0];
					bit_q <= '0;
					if (num_q == '0) begin
						raw_q   <= RAW_SAT;
						state_q <= S_CLAMP;
					end else if (WORD_W'(kd_w[KD_W-1:WORD_W]) >= div_q) begin
						raw_q   <= RAW_SAT;
						state_q <= S_SCALE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= ge_w ? (remsh_w - div_q) : remsh_w;
					quo_q <= {quo_q[WORD_W-2:0], ge_w};
					lo_q  <= lo_q << 1;
					bit_q <= bit_q + 1'b1;
					if (bit_q == 6'd63) begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					raw_q   <= ((q2_w > RAW_SAT) || (q2_w == '0 && rem_q >= div_q)) ?
						RAW_SAT : q2_w;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					if (!fraction_q) begin
						raw_q <= WORD_W'(raw_q * SCALE_10K);
					end
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					if (load_out) begin
						if (raw_q < WORD_W'(tempo_min_q)) begin
							tempo <= tempo_min_q;
						end else if (raw_q > WORD_W'(tempo_max_q)) begin
							tempo <= tempo_max_q;
						end else begin
							tempo <= raw_q[TEMPO_W-1:0];
						end
						taps_used <= TAPS_W'(count_q);
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TTE_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= DEPTH_C)
	`TTE_ASSERT_NOW(a_head_range, clk, arst_n, 1'b1, head_q <= AW'(HISTORY_DEPTH - 1))
	`TTE_ASSERT_NEXT(a_tap_kept, clk, arst_n, in_xfer, count_q != '0)
	`TTE_ASSERT_NOW(a_result_src, clk, arst_n, $rose(out_valid), $past(state_q) == S_CLAMP)
endmodule
